>>> rtl/rmts_pkg.sv
// shared types and constants of the rate-monotonic task scheduler
// no dependencies; every other file imports this package
package rmts_pkg;

  localparam int ID_W   = 22;
  localparam int PER_W  = 16;
  localparam int CMP_W  = 16;
  localparam int UTIL_W = 10;
  localparam int QUO_W  = CMP_W + UTIL_W;

  localparam logic [UTIL_W-1:0] UTIL_RESET = 10'd693;
  localparam logic [UTIL_W-1:0] PER_MILLE  = 10'd1000;

  typedef enum logic [1:0] {
    REQ_REGISTER   = 2'd0,
    REQ_YIELD      = 2'd1,
    REQ_DEREGISTER = 2'd2,
    REQ_TICK       = 2'd3
  } req_type_t;

  typedef enum logic [2:0] {
    STS_OK          = 3'd0,
    STS_REFUSED     = 3'd1,
    STS_FULL        = 3'd2,
    STS_UNKNOWN     = 3'd3,
    STS_MISSED      = 3'd4,
    STS_ZERO_PERIOD = 3'd5
  } status_t;

  localparam logic [1:0] RS_RUNNING  = 2'd1;
  localparam logic [1:0] RS_READY    = 2'd2;
  localparam logic [1:0] RS_SLEEPING = 2'd3;

  typedef struct packed {
    req_type_t          kind;
    logic [ID_W-1:0]    id;
    logic [PER_W-1:0]   period;
    logic [QUO_W-1:0]   util;
  } rmts_req_t;

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} front_state_t;

  typedef enum logic [2:0] {B_IDLE, B_OP, B_PRE, B_DISP, B_COMMIT} back_state_t;

endpackage

>>> rtl/rmts_front.sv
// front end: accepts request beats and computes per-mille utilization
// with a restoring divider; depends on rmts_pkg
module rmts_front import rmts_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_req_type,
  input  logic [ID_W-1:0]   in_task_id,
  input  logic [PER_W-1:0]  in_period_ms,
  input  logic [CMP_W-1:0]  in_compute_ms,
  output logic              q_push,
  output rmts_req_t         q_data,
  input  logic              q_full
);

  localparam int STEP_W = $clog2(QUO_W);

  front_state_t       state_r, state_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  req_type_t          kind_r;
  logic [ID_W-1:0]    id_r;
  logic [PER_W-1:0]   period_r;
  logic [QUO_W-1:0]   work_r, work_nxt;
  logic [PER_W-1:0]   rem_r, rem_nxt;
  logic [PER_W:0]     trial;
  logic               ge;
  logic               accept;

  assign accept = in_valid && in_ready;

  // one quotient bit per cycle
  assign trial    = {rem_r, work_r[QUO_W-1]};
  assign ge       = trial >= {1'b0, period_r};
  assign rem_nxt  = ge ? PER_W'(trial - {1'b0, period_r}) : trial[PER_W-1:0];
  assign work_nxt = {work_r[QUO_W-2:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r   <= req_type_t'(in_req_type);
      id_r     <= in_task_id;
      period_r <= in_period_ms;
      work_r   <= {{UTIL_W{1'b0}}, in_compute_ms} * QUO_W'(PER_MILLE);
      rem_r    <= '0;
    end else if (state_r == F_DIV) begin
      work_r <= work_nxt;
      rem_r  <= rem_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    in_ready  = 1'b0;
    q_push    = 1'b0;
    unique case (state_r)
      F_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          step_nxt = '0;
          if (req_type_t'(in_req_type) == REQ_REGISTER && in_period_ms != '0) begin
            state_nxt = F_DIV;
          end else begin
            state_nxt = F_PUSH;
          end
        end
      end
      F_DIV: begin
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(QUO_W - 1)) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  assign q_data = '{kind: kind_r, id: id_r, period: period_r, util: work_r};

endmodule

>>> rtl/rmts_fifo.sv
// two-entry request queue between front end and task engine
// depends on rmts_pkg for the request type
module rmts_fifo import rmts_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  rmts_req_t wr_data,
  output logic      full,
  input  logic      pop,
  output rmts_req_t rd_data,
  output logic      empty
);

  rmts_req_t  mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full    = count_r == 2'd2;
  assign empty   = count_r == 2'd0;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push && !full) wr_ptr_r <= ~wr_ptr_r;
      if (pop && !empty) rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + 2'(push && !full) - 2'(pop && !empty);
    end
  end

endmodule

>>> rtl/rmts_back.sv
// task engine: slot table, tick time, request execution and dispatch walk
// depends on rmts_pkg
module rmts_back import rmts_pkg::*; #(
  parameter int MAX_TASKS = 16,
  parameter int TIME_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  output logic              q_pop,
  input  rmts_req_t         q_data,
  input  logic [UTIL_W-1:0] limit,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_status,
  output logic              out_running_valid,
  output logic [ID_W-1:0]   out_running_id,
  output logic [UTIL_W-1:0] out_utilization_sum
);

  localparam int IW = $clog2(MAX_TASKS);

  back_state_t           state_r, state_nxt;
  rmts_req_t             req_r;
  logic [IW-1:0]         cnt_r, cnt_nxt;
  status_t               status_r, status_nxt;
  logic [UTIL_W-1:0]     sum_r, sum_nxt;
  logic [TIME_BITS-1:0]  tick_r, tick_nxt;
  logic [IW-1:0]         cur_r, cur_nxt;
  logic                  cur_valid_r, cur_valid_nxt;
  logic                  have_r, have_nxt;
  logic [IW-1:0]         best_r, best_nxt;
  logic [PER_W-1:0]      best_per_r, best_per_nxt;
  logic [ID_W-1:0]       best_id_r, best_id_nxt;

  logic [MAX_TASKS-1:0]  used_r, armed_r;
  logic [ID_W-1:0]       id_mem   [MAX_TASKS];
  logic [PER_W-1:0]      per_mem  [MAX_TASKS];
  logic [UTIL_W-1:0]     util_mem [MAX_TASKS];
  logic [1:0]            run_mem  [MAX_TASKS];
  logic [TIME_BITS-1:0]  rel_mem  [MAX_TASKS];

  logic                  out_valid_r;
  logic [2:0]            out_status_r;
  logic                  out_rv_r;
  logic [ID_W-1:0]       out_id_r;
  logic [UTIL_W-1:0]     out_sum_r;
  logic                  out_ld;

  logic                  w_alloc, w_used_clr, w_run_en, w_arm_set, w_arm_clr, w_rel_en;
  logic [1:0]            w_run_val;

  logic                  rd_used, rd_armed, match, last;
  logic [1:0]            rd_run;
  logic [TIME_BITS-1:0]  rd_rel, next_rel;
  logic                  over;

  assign rd_used  = used_r[cnt_r];
  assign rd_armed = armed_r[cnt_r];
  assign rd_run   = run_mem[cnt_r];
  assign rd_rel   = rel_mem[cnt_r];
  assign match    = rd_used && (id_mem[cnt_r] == req_r.id);
  assign last     = cnt_r == IW'(MAX_TASKS - 1);
  assign next_rel = rd_rel + TIME_BITS'(per_mem[cnt_r]);
  assign over     = ((QUO_W+1)'(q_data.util) + (QUO_W+1)'(sum_r)) > (QUO_W+1)'(limit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      cnt_r       <= '0;
      sum_r       <= '0;
      tick_r      <= '0;
      cur_r       <= '0;
      cur_valid_r <= 1'b0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
      used_r      <= '0;
      armed_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      tick_r      <= tick_nxt;
      cur_r       <= cur_nxt;
      cur_valid_r <= cur_valid_nxt;
      have_r      <= have_nxt;
      if (out_ld) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (w_alloc) begin
        used_r[cnt_r]  <= 1'b1;
        armed_r[cnt_r] <= 1'b0;
      end
      if (w_used_clr) used_r[cnt_r]  <= 1'b0;
      if (w_arm_set)  armed_r[cnt_r] <= 1'b1;
      if (w_arm_clr)  armed_r[cnt_r] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) req_r <= q_data;
    status_r   <= status_nxt;
    best_r     <= best_nxt;
    best_per_r <= best_per_nxt;
    best_id_r  <= best_id_nxt;
    if (w_alloc) begin
      id_mem[cnt_r]   <= req_r.id;
      per_mem[cnt_r]  <= req_r.period;
      util_mem[cnt_r] <= req_r.util[UTIL_W-1:0];
      run_mem[cnt_r]  <= RS_SLEEPING;
      rel_mem[cnt_r]  <= tick_r;
    end
    if (w_run_en) run_mem[cnt_r] <= w_run_val;
    if (w_rel_en) rel_mem[cnt_r] <= next_rel;
    if (out_ld) begin
      out_status_r <= status_r;
      out_rv_r     <= have_r;
      out_id_r     <= have_r ? best_id_r : '0;
      out_sum_r    <= sum_r;
    end
  end

  always_comb begin
    logic stop;
    stop          = 1'b0;
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    status_nxt    = status_r;
    sum_nxt       = sum_r;
    tick_nxt      = tick_r;
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    have_nxt      = have_r;
    best_nxt      = best_r;
    best_per_nxt  = best_per_r;
    best_id_nxt   = best_id_r;
    q_pop         = 1'b0;
    out_ld        = 1'b0;
    w_alloc       = 1'b0;
    w_used_clr    = 1'b0;
    w_run_en      = 1'b0;
    w_run_val     = RS_READY;
    w_arm_set     = 1'b0;
    w_arm_clr     = 1'b0;
    w_rel_en      = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          cnt_nxt = '0;
          state_nxt = B_OP;
          unique case (q_data.kind)
            REQ_REGISTER: begin
              if (q_data.period == '0) begin
                status_nxt = STS_ZERO_PERIOD;
                state_nxt  = B_PRE;
                cnt_nxt    = cur_r;
              end else if (over) begin
                status_nxt = STS_REFUSED;
                state_nxt  = B_PRE;
                cnt_nxt    = cur_r;
              end else begin
                status_nxt = STS_FULL;
              end
            end
            REQ_YIELD, REQ_DEREGISTER: status_nxt = STS_UNKNOWN;
            REQ_TICK: begin
              status_nxt = STS_OK;
              tick_nxt   = tick_r + 1'b1;
            end
            default: status_nxt = STS_OK;
          endcase
        end
      end
      B_OP: begin
        unique case (req_r.kind)
          REQ_REGISTER: begin
            if (!rd_used) begin
              w_alloc    = 1'b1;
              sum_nxt    = sum_r + req_r.util[UTIL_W-1:0];
              status_nxt = STS_OK;
              stop       = 1'b1;
            end
          end
          REQ_YIELD: begin
            if (match) begin
              w_run_en  = 1'b1;
              w_run_val = RS_SLEEPING;
              stop      = 1'b1;
              if (next_rel > tick_r) begin
                w_rel_en   = 1'b1;
                w_arm_set  = 1'b1;
                status_nxt = STS_OK;
              end else begin
                status_nxt = STS_MISSED;
              end
            end
          end
          REQ_DEREGISTER: begin
            if (match) begin
              w_used_clr = 1'b1;
              w_arm_clr  = 1'b1;
              sum_nxt    = sum_r - util_mem[cnt_r];
              status_nxt = STS_OK;
              if (cur_valid_r && cur_r == cnt_r) cur_valid_nxt = 1'b0;
            end
          end
          REQ_TICK: begin
            if (rd_used && rd_armed && rd_rel == tick_r) begin
              w_run_en  = 1'b1;
              w_run_val = RS_READY;
              w_arm_clr = 1'b1;
            end
          end
          default: stop = 1'b1;
        endcase
        if (stop || last) begin
          state_nxt = B_PRE;
          cnt_nxt   = cur_r;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      B_PRE: begin
        if (cur_valid_r && rd_used && rd_run == RS_RUNNING) begin
          w_run_en  = 1'b1;
          w_run_val = RS_READY;
        end
        cur_valid_nxt = 1'b0;
        have_nxt      = 1'b0;
        cnt_nxt       = '0;
        state_nxt     = B_DISP;
      end
      B_DISP: begin
        if (rd_used && rd_run == RS_READY && (!have_r || per_mem[cnt_r] < best_per_r)) begin
          have_nxt     = 1'b1;
          best_nxt     = cnt_r;
          best_per_nxt = per_mem[cnt_r];
          best_id_nxt  = id_mem[cnt_r];
        end
        if (last) begin
          cnt_nxt   = best_nxt;
          state_nxt = B_COMMIT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      B_COMMIT: begin
        if (!out_valid_r || out_ready) begin
          out_ld = 1'b1;
          if (have_r) begin
            w_run_en      = 1'b1;
            w_run_val     = RS_RUNNING;
            cur_nxt       = cnt_r;
            cur_valid_nxt = 1'b1;
          end
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_running_valid   = out_rv_r;
  assign out_running_id      = out_id_r;
  assign out_utilization_sum = out_sum_r;

endmodule

>>> rtl/rate_monotonic_task_scheduler.sv
// top level of the rate-monotonic task scheduler
// depends on rmts_pkg, rmts_front, rmts_fifo and rmts_back
//
// Each request beat (register, yield, deregister, tick) yields exactly one
// result beat. The front end takes a beat and, for a register request with
// a nonzero period, runs the per-mille division compute*1000/period; the
// task engine then walks the slot table once to execute the request and
// once more to pick the ready task with the shortest period. A two-entry
// queue lets the divider work on the next register request while the
// engine is still busy, and the result register lets the engine walk the
// table for the next request while the previous result beat waits. Ties
// between equal periods go to the lowest slot. utilization_limit resets to
// 693; the user must write it through cfg_wr_en/cfg_wr_data only while no
// request is in flight, and the block itself does not enforce this.
module rate_monotonic_task_scheduler import rmts_pkg::*; #(
  parameter int MAX_TASKS = 16,
  parameter int TIME_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  // request channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_req_type,
  input  logic [ID_W-1:0]   in_task_id,
  input  logic [PER_W-1:0]  in_period_ms,
  input  logic [CMP_W-1:0]  in_compute_ms,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_status,
  output logic              out_running_valid,
  output logic [ID_W-1:0]   out_running_id,
  output logic [UTIL_W-1:0] out_utilization_sum,
  // configuration
  input  logic              cfg_wr_en,
  input  logic [UTIL_W-1:0] cfg_wr_data
);

  // admission bound
  logic [UTIL_W-1:0] limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= UTIL_RESET;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  // queue between divider and engine
  logic      q_push, q_full, q_pop, q_empty;
  rmts_req_t q_wr, q_rd;

  rmts_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_task_id    (in_task_id),
    .in_period_ms  (in_period_ms),
    .in_compute_ms (in_compute_ms),
    .q_push        (q_push),
    .q_data        (q_wr),
    .q_full        (q_full)
  );

  rmts_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd),
    .empty   (q_empty)
  );

  // slot table, tick time and dispatch
  rmts_back #(
    .MAX_TASKS (MAX_TASKS),
    .TIME_BITS (TIME_BITS)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_empty             (q_empty),
    .q_pop               (q_pop),
    .q_data              (q_rd),
    .limit               (limit_r),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_running_valid   (out_running_valid),
    .out_running_id      (out_running_id),
    .out_utilization_sum (out_utilization_sum)
  );

endmodule

>>> rtl/rmts_checker.sv
// port-level checks for the rate-monotonic task scheduler
// depends on rmts_pkg; bound to rate_monotonic_task_scheduler
module rmts_checker import rmts_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [2:0]        out_status,
  input logic              out_running_valid,
  input logic [ID_W-1:0]   out_running_id,
  input logic [UTIL_W-1:0] out_utilization_sum
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_running_id) && $stable(out_utilization_sum))
    else $error("result beat changed while stalled");

  a_idle_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_running_valid |-> out_running_id == '0)
    else $error("running id set with no running task");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= 3'(STS_ZERO_PERIOD))
    else $error("undefined status code");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat after reset");

endmodule

bind rate_monotonic_task_scheduler rmts_checker u_rmts_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_status          (out_status),
  .out_running_valid   (out_running_valid),
  .out_running_id      (out_running_id),
  .out_utilization_sum (out_utilization_sum)
);

>>> tb/rate_monotonic_task_scheduler_tb.sv
// self-checking testbench of the rate-monotonic task scheduler
// depends on rmts_pkg and rate_monotonic_task_scheduler; holds its own scheduler predictor
module rate_monotonic_task_scheduler_tb;
  import rmts_pkg::*;

  localparam int NSLOT = 16;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    req_type_t         kind;
    logic [ID_W-1:0]   id;
    logic [PER_W-1:0]  period;
    logic [CMP_W-1:0]  comp;
  } sched_req_t;

  typedef struct packed {
    status_t           status;
    logic              run_valid;
    logic [ID_W-1:0]   run_id;
    logic [UTIL_W-1:0] util_sum;
  } sched_rsp_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [1:0] in_req_type;
  logic [ID_W-1:0] in_task_id;
  logic [PER_W-1:0] in_period_ms;
  logic [CMP_W-1:0] in_compute_ms;
  logic out_valid;
  logic out_ready;
  logic [2:0] out_status;
  logic out_running_valid;
  logic [ID_W-1:0] out_running_id;
  logic [UTIL_W-1:0] out_utilization_sum;
  logic cfg_wr_en;
  logic [UTIL_W-1:0] cfg_wr_data;

  rate_monotonic_task_scheduler i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_req_type        (in_req_type),
    .in_task_id         (in_task_id),
    .in_period_ms       (in_period_ms),
    .in_compute_ms      (in_compute_ms),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_running_valid  (out_running_valid),
    .out_running_id     (out_running_id),
    .out_utilization_sum(out_utilization_sum),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data)
  );

  // predictor copy of the scheduler state
  logic [UTIL_W-1:0] m_limit;
  logic              m_used   [NSLOT];
  logic [ID_W-1:0]   m_id     [NSLOT];
  logic [PER_W-1:0]  m_period [NSLOT];
  logic [UTIL_W-1:0] m_util   [NSLOT];
  logic [1:0]        m_state  [NSLOT];
  logic              m_armed  [NSLOT];
  logic [31:0]       m_release[NSLOT];
  logic [UTIL_W-1:0] m_sum;
  logic [31:0]       m_now;
  int                m_cur;
  logic              m_cur_valid;

  sched_req_t pending_reqs[$];
  sched_rsp_t expected_rsps[$];
  int  errors = 0;
  int  idle_cycles = 0;

  // small pool of ids so that yields and deregisters hit live tasks
  logic [ID_W-1:0] id_pool[8];

  function automatic void sched_reset();
    m_limit = UTIL_RESET;
    for (int i = 0; i < NSLOT; i++) begin
      m_used[i] = 0; m_armed[i] = 0; m_id[i] = '0; m_period[i] = '0;
      m_util[i] = '0; m_state[i] = '0; m_release[i] = '0;
    end
    m_sum = '0; m_now = '0; m_cur = 0; m_cur_valid = 0;
  endfunction

  function automatic sched_rsp_t sched_predict(sched_req_t r);
    sched_rsp_t rsp;
    status_t st;
    logic [31:0] u;
    logic [31:0] nxt;
    bit found;
    int best;
    st = STS_OK;
    found = 0;
    case (r.kind)
      REQ_REGISTER: begin
        if (r.period == 0) begin
          st = STS_ZERO_PERIOD;
        end else begin
          u = (32'(r.comp) * 32'd1000) / 32'(r.period);
          if (u + 32'(m_sum) > 32'(m_limit)) begin
            st = STS_REFUSED;
          end else begin
            st = STS_FULL;
            for (int i = 0; i < NSLOT; i++) begin
              if (!found && !m_used[i]) begin
                found = 1;
                m_used[i] = 1; m_id[i] = r.id; m_period[i] = r.period;
                m_util[i] = u[UTIL_W-1:0]; m_state[i] = RS_SLEEPING;
                m_armed[i] = 0; m_release[i] = m_now;
                m_sum = m_sum + u[UTIL_W-1:0];
                st = STS_OK;
              end
            end
          end
        end
      end
      REQ_YIELD: begin
        st = STS_UNKNOWN;
        for (int i = 0; i < NSLOT; i++) begin
          if (!found && m_used[i] && m_id[i] == r.id) begin
            found = 1;
            m_state[i] = RS_SLEEPING;
            nxt = m_release[i] + 32'(m_period[i]);
            if (nxt > m_now) begin
              m_release[i] = nxt; m_armed[i] = 1; st = STS_OK;
            end else begin
              st = STS_MISSED;
            end
          end
        end
      end
      REQ_DEREGISTER: begin
        for (int i = 0; i < NSLOT; i++) begin
          if (m_used[i] && m_id[i] == r.id) begin
            found = 1;
            m_used[i] = 0; m_armed[i] = 0;
            m_sum = m_sum - m_util[i];
            if (m_cur_valid && m_cur == i) m_cur_valid = 0;
          end
        end
        st = found ? STS_OK : STS_UNKNOWN;
      end
      default: begin
        m_now = m_now + 1;
        for (int i = 0; i < NSLOT; i++) begin
          if (m_used[i] && m_armed[i] && m_release[i] == m_now) begin
            m_state[i] = RS_READY; m_armed[i] = 0;
          end
        end
      end
    endcase
    // preempt, then pick shortest period, lowest slot on ties
    if (m_cur_valid && m_used[m_cur] && m_state[m_cur] == RS_RUNNING)
      m_state[m_cur] = RS_READY;
    m_cur_valid = 0;
    best = -1;
    for (int i = 0; i < NSLOT; i++) begin
      if (m_used[i] && m_state[i] == RS_READY &&
          (best < 0 || m_period[i] < m_period[best])) best = i;
    end
    if (best >= 0) begin
      m_state[best] = RS_RUNNING; m_cur = best; m_cur_valid = 1;
    end
    rsp.status    = st;
    rsp.run_valid = m_cur_valid;
    rsp.run_id    = m_cur_valid ? m_id[m_cur] : '0;
    rsp.util_sum  = m_sum;
    return rsp;
  endfunction

  function automatic sched_req_t make_req(req_type_t k, logic [ID_W-1:0] id,
                                          logic [PER_W-1:0] p, logic [CMP_W-1:0] c);
    sched_req_t r;
    r.kind = k; r.id = id; r.period = p; r.comp = c;
    return r;
  endfunction

  // random request, mostly well-formed traffic on the id pool
  function automatic sched_req_t rand_req();
    int sel;
    logic [ID_W-1:0] id;
    logic [PER_W-1:0] p;
    logic [CMP_W-1:0] c;
    sel = $urandom_range(0, 99);
    id = ($urandom_range(0, 9) == 0) ? ID_W'($urandom) : id_pool[$urandom_range(0, 7)];
    if ($urandom_range(0, 9) == 0) begin
      p = PER_W'($urandom);
      c = CMP_W'($urandom);
    end else begin
      p = PER_W'($urandom_range(1, 12));
      c = CMP_W'($urandom_range(0, 2));
      if ($urandom_range(0, 4) == 0) c = CMP_W'($urandom_range(0, 600));
      if ($urandom_range(0, 4) == 0) p = PER_W'($urandom_range(0, 3000));
    end
    if (sel < 22) return make_req(REQ_REGISTER, id, p, c);
    if (sel < 50) return make_req(REQ_YIELD, id, PER_W'($urandom), CMP_W'($urandom));
    if (sel < 58) return make_req(REQ_DEREGISTER, id, PER_W'($urandom), CMP_W'($urandom));
    return make_req(REQ_TICK, id, PER_W'($urandom), CMP_W'($urandom));
  endfunction

  // clock (the single reset is driven from the main initial block)
  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // driver: bursts of beats with random gaps
  int burst_left = 0;
  int gap_left = 0;
  bit hold_off = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid      <= 0;
      in_req_type   <= '0;
      in_task_id    <= '0;
      in_period_ms  <= '0;
      in_compute_ms <= '0;
    end else if (in_valid && !in_ready) begin
      // payload held until the beat is taken
    end else begin
      if (in_valid) begin
        expected_rsps.push_back(sched_predict(pending_reqs.pop_front()));
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 0;
      end else if (!hold_off && pending_reqs.size() > 0) begin
        // head of the queue is the next beat once the taken one is popped
        in_valid      <= 1;
        in_req_type   <= pending_reqs[0].kind;
        in_task_id    <= pending_reqs[0].id;
        in_period_ms  <= pending_reqs[0].period;
        in_compute_ms <= pending_reqs[0].comp;
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(0, 12);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
        end
      end else begin
        in_valid <= 0;
      end
    end
  end

  // monitor: receiver stall pattern plus field-by-field compare
  int stall_mode = 0;
  int stall_cnt = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected result beat status=%0d id=%0h", $time,
                   out_status, out_running_id);
          errors++;
        end else begin
          sched_rsp_t e;
          e = expected_rsps.pop_front();
          if (out_status !== e.status) begin
            $display("%0t: status exp %0d got %0d", $time, e.status, out_status);
            errors++;
          end
          if (out_running_valid !== e.run_valid) begin
            $display("%0t: running_valid exp %0d got %0d", $time, e.run_valid,
                     out_running_valid);
            errors++;
          end
          if (out_running_id !== e.run_id) begin
            $display("%0t: running_id exp %0h got %0h", $time, e.run_id, out_running_id);
            errors++;
          end
          if (out_utilization_sum !== e.util_sum) begin
            $display("%0t: utilization_sum exp %0d got %0d", $time, e.util_sum,
                     out_utilization_sum);
            errors++;
          end
        end
      end
      // stall pattern cycles through always-ready, periodic and random phases
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt % 500 == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: out_ready <= 1;
        1: out_ready <= (stall_cnt % 7) < 3;
        default: out_ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // watchdog on cycles with no accepted beat
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic drain();
    wait (pending_reqs.size() == 0 && !in_valid);
    wait (expected_rsps.size() == 0);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_limit(logic [UTIL_W-1:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1;
    cfg_wr_data <= v;
    m_limit = v;
    @(posedge clk);
    cfg_wr_en <= 0;
  endtask

  initial begin
    logic [UTIL_W-1:0] limits[5];
    rst_n = 0; cfg_wr_en = 0; cfg_wr_data = '0;
    sched_reset();
    for (int i = 0; i < 8; i++) id_pool[i] = ID_W'($urandom);
    id_pool[0] = '0; id_pool[1] = '1;
    repeat (3) @(posedge clk);
    rst_n <= 1;

    // directed: field extremes, each request kind, admission and dispatch cases
    pending_reqs.push_back(make_req(REQ_REGISTER, id_pool[0], 16'd0, 16'd5));
    pending_reqs.push_back(make_req(REQ_YIELD, id_pool[1], '0, '0));
    pending_reqs.push_back(make_req(REQ_DEREGISTER, id_pool[1], '1, '1));
    pending_reqs.push_back(make_req(REQ_REGISTER, id_pool[1], 16'd4, 16'd1));
    pending_reqs.push_back(make_req(REQ_REGISTER, id_pool[0], 16'd4, 16'd1));
    pending_reqs.push_back(make_req(REQ_REGISTER, id_pool[2], '1, '1));
    pending_reqs.push_back(make_req(REQ_REGISTER, id_pool[3], 16'd1, '1));
    pending_reqs.push_back(make_req(REQ_YIELD, id_pool[1], '0, '0));
    pending_reqs.push_back(make_req(REQ_YIELD, id_pool[0], '0, '0));
    for (int i = 0; i < 5; i++) pending_reqs.push_back(make_req(REQ_TICK, '1, '1, '1));
    pending_reqs.push_back(make_req(REQ_YIELD, id_pool[1], '0, '0));
    pending_reqs.push_back(make_req(REQ_DEREGISTER, id_pool[0], '0, '0));
    for (int i = 0; i < 9; i++)
      pending_reqs.push_back(make_req(REQ_REGISTER, ID_W'(i + 100), 16'd100, 16'd1));
    pending_reqs.push_back(make_req(REQ_REGISTER, ID_W'(200), 16'd100, 16'd1));
    pending_reqs.push_back(make_req(REQ_REGISTER, ID_W'(201), 16'd100, 16'd1));
    drain();

    // random phases across limit settings; one phase waits for all results
    limits[0] = 10'd1000; limits[1] = 10'd0; limits[2] = 10'd1023;
    limits[3] = 10'd500; limits[4] = UTIL_RESET;
    for (int ph = 0; ph < 5; ph++) begin
      write_limit(limits[ph]);
      for (int i = 0; i < 245; i++) pending_reqs.push_back(rand_req());
      if (ph == 2) begin
        wait (pending_reqs.size() < 120);
        hold_off = 1;
        wait (expected_rsps.size() == 0 && !in_valid);
        hold_off = 0;
      end
      drain();
    end

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
